// ===== rtl/core/tmp_pkg.sv =====
// tmp_pkg: shared types and register codes for the tile mean pixelate block.
// No dependencies; imported by every module in rtl/core.
package tmp_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_TILE_SIZE    = 2'd0;
   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd2;

   localparam int TILE_CFG_W = 7;
   localparam int DIM_CFG_W  = 13;
   localparam int COLOR_W    = 8;
   localparam int POS_W      = 12;
   localparam int EXTENT_W   = 7;

   // per-pixel classification made by the front end
   typedef struct packed {
      logic first;       // first pixel of a tile column in this band: overwrite sums
      logic emit;        // last pixel of a tile: report the mean
      logic frame_done;  // last pixel of the image
   } tmp_flags_type;

endpackage

// ===== rtl/core/tile_mean_pixelate.sv =====
// tile_mean_pixelate: top level of the mosaic block averager.
// Depends on tmp_pkg, tmp_front, tmp_fifo, tmp_back.
//
//  channel   ports                                          handshake
//  -------   --------------------------------------------   ---------------------
//  pixel     req_red, req_green, req_blue                   push / full
//  result    rsp_tile_row .. rsp_frame_done                 pop / empty
//  config    csr_index, csr_data                            csr_valid / csr_ready
//
// The front end counts raster position and tags each pixel at once; up to four
// tagged pixels wait in a queue. The back end updates the band sum memory per pixel
// (registered read, then add and write back); a tile's last pixel then runs the
// restoring mean divide and loads the result register. The back end pops no new
// pixel until the last is through. Reset is synchronous; the sum memory needs no
// clearing since every tile restarts its sums. A full result register stalls the
// back end, which can fill the queue and raise full; csr_ready stays high.
module tile_mean_pixelate #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096,
   parameter int MAX_TILE   = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [tmp_pkg::COLOR_W-1:0]   req_red,
   input  logic [tmp_pkg::COLOR_W-1:0]   req_green,
   input  logic [tmp_pkg::COLOR_W-1:0]   req_blue,
   output logic                          empty,
   input  logic                          pop,
   output logic [tmp_pkg::POS_W-1:0]     rsp_tile_row,
   output logic [tmp_pkg::POS_W-1:0]     rsp_tile_col,
   output logic [tmp_pkg::EXTENT_W-1:0]  rsp_tile_rows,
   output logic [tmp_pkg::EXTENT_W-1:0]  rsp_tile_cols,
   output logic [tmp_pkg::COLOR_W-1:0]   rsp_mean_red,
   output logic [tmp_pkg::COLOR_W-1:0]   rsp_mean_green,
   output logic [tmp_pkg::COLOR_W-1:0]   rsp_mean_blue,
   output logic                          rsp_frame_done,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic [tmp_pkg::DIM_CFG_W-1:0] csr_data
);
   import tmp_pkg::*;

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int TSW = $clog2(MAX_TILE) + 1;
   localparam int FW  = $bits(tmp_flags_type);
   localparam int RGBW = 3 * COLOR_W;
   localparam int EW  = FW + CW + 2 * POS_W + 2 * TSW + RGBW;

   logic take;
   tmp_flags_type f_flags, b_flags;
   logic [CW-1:0] f_idx, b_idx;
   logic [POS_W-1:0] f_row, f_col, b_row, b_col;
   logic [TSW-1:0] f_rows, f_cols, b_rows, b_cols;
   logic [RGBW-1:0] b_rgb;
   logic [EW-1:0] q_wr, q_rd;
   logic q_pop, q_empty;

   // config writes always land at once
   assign csr_ready = 1'b1;
   assign take      = push && !full;

   tmp_front #(
      .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_TILE(MAX_TILE)
   ) u_front (
      .clock, .reset,
      .csr_write(csr_valid), .csr_index, .csr_data,
      .take,
      .flags(f_flags), .idx(f_idx), .tile_row(f_row), .tile_col(f_col),
      .rows(f_rows), .cols(f_cols)
   );

   // pack tagged pixel for the queue; red sits in the low byte as color 0 of the back end
   assign q_wr = {f_flags, f_idx, f_row, f_col, f_rows, f_cols, req_blue, req_green, req_red};

   tmp_fifo #(.DATA_W(EW), .DEPTH(4)) u_fifo (
      .clock, .reset,
      .wr_en(take), .wr_data(q_wr),
      .rd_en(q_pop), .rd_data(q_rd),
      .full, .empty(q_empty)
   );

   assign {b_flags, b_idx, b_row, b_col, b_rows, b_cols, b_rgb} = q_rd;

   tmp_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_TILE(MAX_TILE)) u_back (
      .clock, .reset,
      .in_empty(q_empty), .in_pop(q_pop),
      .in_flags(b_flags), .in_idx(b_idx), .in_tile_row(b_row), .in_tile_col(b_col),
      .in_rows(b_rows), .in_cols(b_cols), .in_rgb(b_rgb),
      .out_pop(pop), .out_empty(empty),
      .out_tile_row(rsp_tile_row), .out_tile_col(rsp_tile_col),
      .out_tile_rows(rsp_tile_rows), .out_tile_cols(rsp_tile_cols),
      .out_mean_red(rsp_mean_red), .out_mean_green(rsp_mean_green),
      .out_mean_blue(rsp_mean_blue), .out_frame_done(rsp_frame_done)
   );

`ifndef SYNTHESIS
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      full |-> !take) else $error("pixel taken while full");
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_tile_row) && $stable(rsp_mean_red)))
      else $error("waiting result changed");
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready) else $error("config port stalled");
`endif
endmodule

// ===== rtl/core/tmp_fifo.sv =====
// tmp_fifo: small synchronous queue between front end and back end.
// Depends on tmp_pkg only by convention; generic data width.
module tmp_fifo #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   output logic [DATA_W-1:0] rd_data,
   output logic              full,
   output logic              empty
);
   import tmp_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [AW-1:0]     wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [AW:0]       count_ff, count_in;

   function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
      logic [AW-1:0] r;
      r = (32'(p) == DEPTH - 1) ? '0 : p + 1'b1;
      return r;
   endfunction

   assign full    = (32'(count_ff) == DEPTH);
   assign empty   = (count_ff == '0);
   assign rd_data = slot_ff[rptr_ff];

   always_comb begin
      wptr_in  = wr_en ? bump(wptr_ff) : wptr_ff;
      rptr_in  = rd_en ? bump(rptr_ff) : rptr_ff;
      count_in = count_ff;
      if (wr_en && !rd_en) count_in = count_ff + 1'b1;
      if (rd_en && !wr_en) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) slot_ff[wptr_ff] <= wr_data;
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !wr_en || rd_en) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !rd_en) else $error("queue underflow");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (wr_en && !rd_en) |=> !empty) else $error("queue lost an entry");
`endif
endmodule

// ===== rtl/core/tmp_front.sv =====
// tmp_front: configuration registers, raster counters and per-pixel classification.
// Depends on tmp_pkg.
module tmp_front #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096,
   parameter int MAX_TILE   = 64,
   localparam int CW  = $clog2(MAX_WIDTH),
   localparam int RW  = $clog2(MAX_HEIGHT),
   localparam int TW  = $clog2(MAX_TILE),
   localparam int TSW = TW + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [1:0]                    csr_index,
   input  logic [tmp_pkg::DIM_CFG_W-1:0] csr_data,
   input  logic                          take,
   output tmp_pkg::tmp_flags_type        flags,
   output logic [CW-1:0]                 idx,
   output logic [tmp_pkg::POS_W-1:0]     tile_row,
   output logic [tmp_pkg::POS_W-1:0]     tile_col,
   output logic [TSW-1:0]                rows,
   output logic [TSW-1:0]                cols
);
   import tmp_pkg::*;

   logic [TILE_CFG_W-1:0] tile_cfg_ff;
   logic [DIM_CFG_W-1:0]  width_cfg_ff, height_cfg_ff;
   logic [CW-1:0] col_ff, tidx_ff;
   logic [RW-1:0] row_ff;
   logic [TW-1:0] rib_ff, cit_ff;

   logic [TSW-1:0] ts;
   logic [CW:0]    w;
   logic [RW:0]    h;
   logic row_end, frame_end, tile_col_end, last_row, band_end;
   logic [31:0] row_base, col_base;

   // clamp registers to their legal ranges
   always_comb begin
      ts = (tile_cfg_ff == '0) ? TSW'(1)
         : (32'(tile_cfg_ff) > MAX_TILE) ? TSW'(MAX_TILE) : TSW'(tile_cfg_ff);
      w  = (width_cfg_ff == '0) ? (CW+1)'(1)
         : (32'(width_cfg_ff) > MAX_WIDTH) ? (CW+1)'(MAX_WIDTH) : (CW+1)'(width_cfg_ff);
      h  = (height_cfg_ff == '0) ? (RW+1)'(1)
         : (32'(height_cfg_ff) > MAX_HEIGHT) ? (RW+1)'(MAX_HEIGHT) : (RW+1)'(height_cfg_ff);
   end

   always_comb begin
      row_end      = ({1'b0, col_ff} + 1'b1) >= w;
      last_row     = ({1'b0, row_ff} + 1'b1) >= h;
      frame_end    = row_end && last_row;
      tile_col_end = row_end || (({1'b0, cit_ff} + 1'b1) >= ts);
      band_end     = last_row || (({1'b0, rib_ff} + 1'b1) >= ts);
      flags.first      = (rib_ff == '0) && (cit_ff == '0);
      flags.emit       = tile_col_end && band_end;
      flags.frame_done = frame_end;
      idx      = tidx_ff;
      row_base = 32'(row_ff) - 32'(rib_ff);
      col_base = 32'(col_ff) - 32'(cit_ff);
      tile_row = row_base[POS_W-1:0];
      tile_col = col_base[POS_W-1:0];
      rows     = {1'b0, rib_ff} + 1'b1;
      cols     = {1'b0, cit_ff} + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_cfg_ff   <= TILE_CFG_W'(8);
         width_cfg_ff  <= DIM_CFG_W'(640);
         height_cfg_ff <= DIM_CFG_W'(480);
         col_ff  <= '0;
         row_ff  <= '0;
         rib_ff  <= '0;
         cit_ff  <= '0;
         tidx_ff <= '0;
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_TILE_SIZE)    tile_cfg_ff   <= csr_data[TILE_CFG_W-1:0];
            if (csr_index == CSR_IMAGE_WIDTH)  width_cfg_ff  <= csr_data;
            if (csr_index == CSR_IMAGE_HEIGHT) height_cfg_ff <= csr_data;
         end
         if (take) begin
            if (row_end) begin
               col_ff  <= '0;
               cit_ff  <= '0;
               tidx_ff <= '0;
               if (frame_end) begin
                  row_ff <= '0;
                  rib_ff <= '0;
               end else begin
                  row_ff <= row_ff + 1'b1;
                  rib_ff <= band_end ? '0 : rib_ff + 1'b1;
               end
            end else begin
               col_ff <= col_ff + 1'b1;
               if (tile_col_end) begin
                  cit_ff  <= '0;
                  tidx_ff <= tidx_ff + 1'b1;
               end else begin
                  cit_ff <= cit_ff + 1'b1;
               end
            end
         end
      end
   end
endmodule

// ===== rtl/core/tmp_back.sv =====
// tmp_back: band sum memory update, shared-step mean divider and result register.
// Depends on tmp_pkg.
module tmp_back #(
   parameter int MAX_WIDTH = 4096,
   parameter int MAX_TILE  = 64,
   localparam int CW  = $clog2(MAX_WIDTH),
   localparam int TW  = $clog2(MAX_TILE),
   localparam int TSW = TW + 1,
   localparam int SW  = tmp_pkg::COLOR_W + 2 * TW,
   localparam int NW  = 2 * TSW
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_empty,
   output logic                          in_pop,
   input  tmp_pkg::tmp_flags_type        in_flags,
   input  logic [CW-1:0]                 in_idx,
   input  logic [tmp_pkg::POS_W-1:0]     in_tile_row,
   input  logic [tmp_pkg::POS_W-1:0]     in_tile_col,
   input  logic [TSW-1:0]                in_rows,
   input  logic [TSW-1:0]                in_cols,
   input  logic [3*tmp_pkg::COLOR_W-1:0] in_rgb,
   input  logic                          out_pop,
   output logic                          out_empty,
   output logic [tmp_pkg::POS_W-1:0]     out_tile_row,
   output logic [tmp_pkg::POS_W-1:0]     out_tile_col,
   output logic [tmp_pkg::EXTENT_W-1:0]  out_tile_rows,
   output logic [tmp_pkg::EXTENT_W-1:0]  out_tile_cols,
   output logic [tmp_pkg::COLOR_W-1:0]   out_mean_red,
   output logic [tmp_pkg::COLOR_W-1:0]   out_mean_green,
   output logic [tmp_pkg::COLOR_W-1:0]   out_mean_blue,
   output logic                          out_frame_done
);
   import tmp_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_SUM, ST_DIV, ST_OUT} state_type;

   localparam int STW = $clog2(SW + 1);

   state_type state_ff;
   logic [3*SW-1:0] mem [MAX_WIDTH];
   logic [3*SW-1:0] rd_ff, sum_in;

   tmp_flags_type          flags_ff;
   logic [CW-1:0]          idx_ff;
   logic [POS_W-1:0]       trow_ff, tcol_ff;
   logic [TSW-1:0]         rows_ff, cols_ff;
   logic [3*COLOR_W-1:0]   rgb_ff;
   logic [SW-1:0]          quo_ff [3];
   logic [SW-1:0]          quo_in [3];
   logic [NW-1:0]          rem_ff [3];
   logic [NW-1:0]          rem_in [3];
   logic [NW-1:0]          den_ff;
   logic [STW-1:0]         step_ff;
   logic                   out_valid_ff, out_load;

   logic [POS_W-1:0]    o_row_ff, o_col_ff;
   logic [EXTENT_W-1:0] o_rows_ff, o_cols_ff;
   logic [COLOR_W-1:0]  o_mean_ff [3];
   logic                o_done_ff;

   assign in_pop   = (state_ff == ST_IDLE) && !in_empty;
   assign out_load = (state_ff == ST_OUT) && (!out_valid_ff || out_pop);

   // add the pixel to its tile column sums, or restart them
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sum_in[c*SW +: SW] = (flags_ff.first ? '0 : rd_ff[c*SW +: SW])
                            + SW'(rgb_ff[c*COLOR_W +: COLOR_W]);
      end
   end

   // one restoring divide step per cycle on all three colors
   always_comb begin
      logic [NW:0] trial;
      for (int c = 0; c < 3; c++) begin
         trial = {rem_ff[c], quo_ff[c][SW-1]};
         if (trial >= {1'b0, den_ff}) begin
            rem_in[c] = NW'(trial - {1'b0, den_ff});
            quo_in[c] = {quo_ff[c][SW-2:0], 1'b1};
         end else begin
            rem_in[c] = trial[NW-1:0];
            quo_in[c] = {quo_ff[c][SW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_pop) rd_ff <= mem[in_idx];
      if (state_ff == ST_SUM) mem[idx_ff] <= sum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (!in_empty) begin
                  flags_ff <= in_flags;
                  idx_ff   <= in_idx;
                  trow_ff  <= in_tile_row;
                  tcol_ff  <= in_tile_col;
                  rows_ff  <= in_rows;
                  cols_ff  <= in_cols;
                  rgb_ff   <= in_rgb;
                  state_ff <= ST_SUM;
               end
            end
            ST_SUM: begin
               for (int c = 0; c < 3; c++) begin
                  quo_ff[c] <= sum_in[c*SW +: SW];
                  rem_ff[c] <= '0;
               end
               den_ff   <= rows_ff * cols_ff;
               step_ff  <= '0;
               state_ff <= flags_ff.emit ? ST_DIV : ST_IDLE;
            end
            ST_DIV: begin
               for (int c = 0; c < 3; c++) begin
                  quo_ff[c] <= quo_in[c];
                  rem_ff[c] <= rem_in[c];
               end
               step_ff <= step_ff + 1'b1;
               if (32'(step_ff) == SW - 1) state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (out_load) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
         if (out_load)     out_valid_ff <= 1'b1;
         else if (out_pop) out_valid_ff <= 1'b0;
      end
   end

   // result register: saturate means, hold until popped
   always_ff @(posedge clock) begin
      if (out_load) begin
         o_row_ff  <= trow_ff;
         o_col_ff  <= tcol_ff;
         o_rows_ff <= EXTENT_W'(rows_ff);
         o_cols_ff <= EXTENT_W'(cols_ff);
         o_done_ff <= flags_ff.frame_done;
         for (int c = 0; c < 3; c++) begin
            o_mean_ff[c] <= (quo_ff[c] > SW'(255)) ? COLOR_W'(255) : quo_ff[c][COLOR_W-1:0];
         end
      end
   end

   assign out_empty      = !out_valid_ff;
   assign out_tile_row   = o_row_ff;
   assign out_tile_col   = o_col_ff;
   assign out_tile_rows  = o_rows_ff;
   assign out_tile_cols  = o_cols_ff;
   assign out_mean_red   = o_mean_ff[0];
   assign out_mean_green = o_mean_ff[1];
   assign out_mean_blue  = o_mean_ff[2];
   assign out_frame_done = o_done_ff;

`ifndef SYNTHESIS
   a_div_only_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> flags_ff.emit) else $error("divide without tile end");
   a_no_clobber: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!out_valid_ff || out_pop)) else $error("result overwritten");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      in_pop |=> (state_ff == ST_SUM)) else $error("pop outside idle");
`endif
endmodule
